FILE: hdl/snt_pkg.sv
package snt_pkg;

  localparam int CNT_W    = 7;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 184;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_ENQUEUE = 3'd2;
  localparam logic [2:0] OP_DEQUEUE = 3'd3;
  localparam logic [2:0] OP_STATS   = 3'd4;
  localparam logic [2:0] OP_REPLACE = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EXISTS    = 3'd3;
  localparam logic [2:0] ST_NO_SPACE  = 3'd4;

  typedef struct packed {
    logic             active;
    logic             linked;
    logic [5:0]       parent;
    logic [CNT_W-1:0] count;
    logic [31:0]      qp;
    logic [47:0]      qb;
    logic [47:0]      ep;
    logic [47:0]      eb;
  } node_rec_t;

endpackage

FILE: hdl/shaper_node_table_with_counters_top.sv
// Channel | Dir | Handshake         | Word
// s       | in  | s_tvalid/s_tready | one operation on the node table
// m       | out | m_tvalid/m_tready | one status and counter result per operation
//
// One operation is worked on at a time. The child-list walk and compaction read the
// child memory one entry at a time, a read state then a check or copy state, and each node
// update is a read then a write of the node memory, which has one read and one write port.
// After reset the node memory is cleared, one entry per cycle, before s_tready rises.
// A stalled result holds in the output register while the next operation is taken
// and worked on.
module shaper_node_table_with_counters_top import snt_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int CHILD_LIMIT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // opcode, node_index, has_parent, parent_index, new_child, packet_bytes, handle_scope
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // status, queue_length, backlog, packet_total, byte_total, zero padding
  output logic [OUT_W-1:0]  m_tdata
);

  localparam int NW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAW = $clog2(SLOTS * CHILD_LIMIT);
  localparam int CD  = SLOTS * CHILD_LIMIT;

  typedef enum logic [26:0] {
    S_CLR  = 27'h0000001, S_IDLE = 27'h0000002, S_DEC  = 27'h0000004,
    S_RN   = 27'h0000008, S_MN   = 27'h0000010, S_RAP  = 27'h0000020,
    S_MAP  = 27'h0000040, S_RDP  = 27'h0000080, S_MDP  = 27'h0000100,
    S_LRD  = 27'h0000200, S_LCK  = 27'h0000400, S_SRD  = 27'h0000800,
    S_SWR  = 27'h0001000, S_DWP  = 27'h0002000, S_RTP  = 27'h0004000,
    S_MTP  = 27'h0008000, S_RRP  = 27'h0010000, S_MRP  = 27'h0020000,
    S_RNW  = 27'h0040000, S_MNW  = 27'h0080000, S_ROL  = 27'h0100000,
    S_MOL  = 27'h0200000, S_RPP  = 27'h0400000, S_MPP  = 27'h0800000,
    S_ROC  = 27'h1000000, S_MOC  = 27'h2000000, S_FIN  = 27'h4000000
  } state_t;

  state_t state, state_next;
  logic [2:0]       op, op_next, st, st_next;
  logic [5:0]       n, n_next, p, p_next, nw, nw_next, pp, pp_next;
  logic             hp, hp_next;
  logic [15:0]      bytes, bytes_next;
  logic [1:0]       scope, scope_next;
  logic [31:0]      rq, rq_next, qpo, qpo_next;
  logic [47:0]      rb, rb_next, rpt, rpt_next, rbt, rbt_next;
  logic [CNT_W-1:0] cnt, cnt_next, i, i_next, lim;
  node_rec_t        prec, prec_next, rec, node_rd, node_wd;
  logic [NW-1:0]    clr_idx, clr_idx_next, node_ra, node_wa;
  logic             node_we, ch_we;
  logic [CAW-1:0]   ch_ra, ch_wa;
  logic [5:0]       ch_rd, ch_wd;
  logic             m_tvalid_next;
  logic [OUT_W-1:0] m_tdata_next;

  node_rec_t node_mem [SLOTS];
  logic [5:0] ch_mem [CD];

  function automatic logic inr(input logic [5:0] x);
    return {5'd0, x} < 11'(SLOTS);
  endfunction

  function automatic logic [NW-1:0] idx(input logic [5:0] x);
    return NW'(x);
  endfunction

  function automatic logic [CAW-1:0] caddr(input logic [5:0] x, input logic [CNT_W-1:0] k);
    return CAW'(idx(x)) * CAW'(CHILD_LIMIT) + CAW'(k);
  endfunction

  function automatic node_rec_t traffic(input node_rec_t r, input logic [15:0] b,
                                        input logic add);
    node_rec_t o;
    o = r;
    if (add) begin
      o.qp = r.qp + 32'd1;
      o.qb = r.qb + {32'd0, b};
      o.ep = r.ep + 48'd1;
      o.eb = r.eb + {32'd0, b};
    end else begin
      o.qp = r.qp - 32'd1;
      o.qb = r.qb - {32'd0, b};
    end
    return o;
  endfunction

  assign lim = CNT_W'(CHILD_LIMIT);

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    ch_rd <= ch_mem[ch_ra];
  end

  always_comb begin
    state_next = state;
    op_next = op; n_next = n; hp_next = hp; p_next = p; nw_next = nw;
    bytes_next = bytes; scope_next = scope; st_next = st; pp_next = pp;
    rq_next = rq; rb_next = rb; rpt_next = rpt; rbt_next = rbt; qpo_next = qpo;
    cnt_next = cnt; i_next = i; prec_next = prec; clr_idx_next = clr_idx;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next = m_tdata;
    s_tready = 1'b0;
    rec = node_rd;
    node_we = 1'b0; node_wa = idx(n); node_wd = node_rd; node_ra = idx(n);
    ch_we = 1'b0; ch_wa = caddr(pp, i); ch_wd = nw; ch_ra = caddr(pp, i);
    case (state)
      S_CLR: begin
        node_we = 1'b1;
        node_wa = clr_idx;
        node_wd = '0;
        clr_idx_next = clr_idx + NW'(1);
        if (clr_idx == NW'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op_next = s_tdata[2:0];
          n_next = s_tdata[8:3];
          hp_next = s_tdata[9];
          p_next = s_tdata[15:10];
          nw_next = s_tdata[21:16];
          bytes_next = s_tdata[37:22];
          scope_next = s_tdata[39:38];
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        rq_next = '0; rb_next = '0; rpt_next = '0; rbt_next = '0;
        st_next = ST_INVALID;
        state_next = S_FIN;
        case (op)
          OP_REPLACE: if (inr(p) && inr(n) && inr(nw)) state_next = S_RRP;
          OP_ADD, OP_DELETE, OP_ENQUEUE, OP_DEQUEUE, OP_STATS:
            if (inr(n)) state_next = S_RN;
          default: state_next = S_FIN;
        endcase
      end
      S_RN: state_next = S_MN;
      S_MN: begin
        state_next = S_FIN;
        st_next = ST_NOT_FOUND;
        case (op)
          OP_ADD: begin
            if (scope == 2'd0) st_next = ST_INVALID;
            else if (rec.active) st_next = ST_EXISTS;
            else begin
              node_we = 1'b1;
              node_wd = '0;
              node_wd.active = 1'b1;
              st_next = ST_OK;
              if (hp) begin
                if (!inr(p)) begin
                  node_wd = '0;
                  st_next = ST_INVALID;
                end else begin
                  node_wd.linked = 1'b1;
                  node_wd.parent = p;
                  state_next = S_RAP;
                end
              end
            end
          end
          OP_DELETE: begin
            if (rec.active) begin
              node_we = 1'b1;
              node_wd = '0;
              st_next = ST_OK;
              if (rec.linked && inr(rec.parent)) begin
                pp_next = rec.parent;
                state_next = S_RDP;
              end
            end
          end
          OP_ENQUEUE, OP_DEQUEUE: begin
            if (rec.active) begin
              node_we = 1'b1;
              node_wd = traffic(rec, bytes, op == OP_ENQUEUE);
              st_next = ST_OK;
              if (rec.linked && inr(rec.parent)) begin
                pp_next = rec.parent;
                state_next = S_RTP;
              end
            end
          end
          default: begin
            if (rec.active) begin
              st_next = ST_OK;
              rq_next = rec.qp;
              rb_next = rec.qb;
              rpt_next = rec.ep;
              rbt_next = rec.eb;
            end
          end
        endcase
      end
      S_RAP: begin
        node_ra = idx(p);
        state_next = S_MAP;
      end
      S_MAP: begin
        node_we = 1'b1;
        state_next = S_FIN;
        if (!rec.active) begin
          node_wd = '0;
          st_next = ST_NOT_FOUND;
        end else if (rec.count >= lim) begin
          node_wd = '0;
          st_next = ST_NO_SPACE;
        end else begin
          node_wa = idx(p);
          node_wd.count = rec.count + CNT_W'(1);
          ch_we = 1'b1;
          ch_wa = caddr(p, rec.count);
          ch_wd = n;
        end
      end
      S_RDP: begin
        node_ra = idx(pp);
        state_next = S_MDP;
      end
      S_MDP: begin
        prec_next = rec;
        cnt_next = (rec.count > lim) ? lim : rec.count;
        i_next = '0;
        state_next = (rec.count == '0) ? S_FIN : S_LRD;
      end
      S_LRD: state_next = S_LCK;
      S_LCK: begin
        if (ch_rd == n) begin
          if (op == OP_REPLACE) begin
            ch_we = 1'b1;
            state_next = S_RNW;
          end else begin
            state_next = (i + CNT_W'(1) < cnt) ? S_SRD : S_DWP;
          end
        end else if (i + CNT_W'(1) >= cnt) begin
          if (op == OP_REPLACE) st_next = ST_NOT_FOUND;
          state_next = S_FIN;
        end else begin
          i_next = i + CNT_W'(1);
          state_next = S_LRD;
        end
      end
      S_SRD: begin
        ch_ra = caddr(pp, i + CNT_W'(1));
        state_next = S_SWR;
      end
      S_SWR: begin
        ch_we = 1'b1;
        ch_wd = ch_rd;
        i_next = i + CNT_W'(1);
        state_next = (i + CNT_W'(2) < cnt) ? S_SRD : S_DWP;
      end
      S_DWP: begin
        node_we = 1'b1;
        node_wa = idx(pp);
        node_wd = prec;
        node_wd.count = cnt - CNT_W'(1);
        state_next = S_FIN;
      end
      S_RTP: begin
        node_ra = idx(pp);
        state_next = S_MTP;
      end
      S_MTP: begin
        node_we = rec.active;
        node_wa = idx(pp);
        node_wd = traffic(rec, bytes, op == OP_ENQUEUE);
        node_wd.ep = rec.ep;
        node_wd.eb = rec.eb;
        state_next = S_FIN;
      end
      S_RRP: begin
        node_ra = idx(p);
        state_next = S_MRP;
      end
      S_MRP: begin
        pp_next = p;
        cnt_next = (rec.count > lim) ? lim : rec.count;
        i_next = '0;
        st_next = ST_NOT_FOUND;
        state_next = (rec.active && rec.count != '0) ? S_LRD : S_FIN;
      end
      S_RNW: begin
        node_ra = idx(nw);
        state_next = S_MNW;
      end
      S_MNW: begin
        node_we = 1'b1;
        node_wa = idx(nw);
        node_wd.linked = 1'b1;
        node_wd.parent = p;
        state_next = S_ROL;
      end
      S_ROL: state_next = S_MOL;
      S_MOL: begin
        qpo_next = rec.qp;
        state_next = S_RPP;
      end
      S_RPP: begin
        node_ra = idx(p);
        state_next = S_MPP;
      end
      S_MPP: begin
        node_we = 1'b1;
        node_wa = idx(p);
        node_wd.qp = rec.qp - qpo;
        state_next = S_ROC;
      end
      S_ROC: state_next = S_MOC;
      S_MOC: begin
        node_we = 1'b1;
        node_wd.qp = '0;
        node_wd.linked = 1'b0;
        node_wd.parent = '0;
        st_next = ST_OK;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next = {5'd0, rbt, rpt, rb, rq, st};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      clr_idx <= clr_idx_next;
      m_tvalid <= m_tvalid_next;
    end
    op <= op_next; n <= n_next; hp <= hp_next; p <= p_next; nw <= nw_next;
    bytes <= bytes_next; scope <= scope_next; st <= st_next; pp <= pp_next;
    rq <= rq_next; rb <= rb_next; rpt <= rpt_next; rbt <= rbt_next; qpo <= qpo_next;
    cnt <= cnt_next; i <= i_next; prec <= prec_next;
    m_tdata <= m_tdata_next;
  end

endmodule

FILE: hdl/snt_checker.sv
module snt_checker import snt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_NO_SPACE)
    else $error("status code out of range");

  a_zero_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[OUT_W-1:3] == '0)
    else $error("failed operation carries counter values");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation is in progress");

endmodule

bind shaper_node_table_with_counters_top snt_checker u_snt_checker (.*);

FILE: tb/sv/shaper_node_table_with_counters_checker.sv
module shaper_node_table_with_counters_checker import snt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               errors,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 64;
  localparam int KIDS  = 8;

  typedef struct packed {
    logic [47:0] btotal;
    logic [47:0] ptotal;
    logic [47:0] backlog;
    logic [31:0] qlen;
    logic [2:0]  status;
  } result_t;

  logic        act   [NODES];
  logic        lnk   [NODES];
  logic [5:0]  par   [NODES];
  int          nkids [NODES];
  logic [5:0]  kids  [NODES][KIDS];
  logic [31:0] qp    [NODES];
  logic [47:0] qb    [NODES];
  logic [47:0] ep    [NODES];
  logic [47:0] eb    [NODES];

  result_t expected_results[$];

  function automatic void wipe(int n);
    act[n] = 1'b0; lnk[n] = 1'b0; par[n] = '0; nkids[n] = 0;
    qp[n] = '0; qb[n] = '0; ep[n] = '0; eb[n] = '0;
  endfunction

  function automatic result_t apply_op(logic [IN_W-1:0] w);
    result_t r;
    logic [2:0] op;
    int n, p, nw, sc, j;
    logic hp;
    logic [47:0] by;
    logic done;
    op = w[2:0]; n = int'(w[8:3]); hp = w[9]; p = int'(w[15:10]); nw = int'(w[21:16]);
    by = {32'd0, w[37:22]}; sc = int'(w[39:38]);
    r = '0;
    r.status = ST_INVALID;
    done = 1'b0;
    case (op)
      OP_ADD: begin
        if (sc == 0) r.status = ST_INVALID;
        else if (act[n]) r.status = ST_EXISTS;
        else begin
          wipe(n);
          act[n] = 1'b1;
          r.status = ST_OK;
          if (hp) begin
            if (!act[p]) r.status = ST_NOT_FOUND;
            else if (nkids[p] >= KIDS) r.status = ST_NO_SPACE;
            if (r.status != ST_OK) begin
              act[n] = 1'b0;
            end else begin
              lnk[n] = 1'b1; par[n] = 6'(p);
              kids[p][nkids[p]] = 6'(n);
              nkids[p]++;
            end
          end
        end
      end
      OP_DELETE: begin
        if (!act[n]) r.status = ST_NOT_FOUND;
        else begin
          if (lnk[n]) begin
            p = int'(par[n]);
            for (int i = 0; i < nkids[p] && !done; i++) begin
              if (int'(kids[p][i]) == n) begin
                for (j = i; j + 1 < nkids[p]; j++) kids[p][j] = kids[p][j+1];
                nkids[p]--;
                done = 1'b1;
              end
            end
          end
          wipe(n);
          r.status = ST_OK;
        end
      end
      OP_ENQUEUE, OP_DEQUEUE: begin
        if (!act[n]) r.status = ST_NOT_FOUND;
        else begin
          r.status = ST_OK;
          if (op == OP_ENQUEUE) begin
            qp[n] += 32'd1; qb[n] += by; ep[n] += 48'd1; eb[n] += by;
          end else begin
            qp[n] -= 32'd1; qb[n] -= by;
          end
          p = int'(par[n]);
          if (lnk[n] && act[p]) begin
            if (op == OP_ENQUEUE) begin
              qp[p] += 32'd1; qb[p] += by;
            end else begin
              qp[p] -= 32'd1; qb[p] -= by;
            end
          end
        end
      end
      OP_STATS: begin
        if (!act[n]) r.status = ST_NOT_FOUND;
        else begin
          r.status = ST_OK;
          r.qlen = qp[n]; r.backlog = qb[n]; r.ptotal = ep[n]; r.btotal = eb[n];
        end
      end
      OP_REPLACE: begin
        if (!act[p]) r.status = ST_NOT_FOUND;
        else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < nkids[p] && !done; i++) begin
            if (int'(kids[p][i]) == n) begin
              kids[p][i] = 6'(nw);
              lnk[nw] = 1'b1; par[nw] = 6'(p);
              qp[p] -= qp[n];
              qp[n] = '0;
              lnk[n] = 1'b0; par[n] = '0;
              r.status = ST_OK;
              done = 1'b1;
            end
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      for (int i = 0; i < NODES; i++) wipe(i);
      expected_results.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(apply_op(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[178:0];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch status %0d/%0d qlen %h/%h backlog %h/%h",
                     $time, want.status, got.status, want.qlen, got.qlen,
                     want.backlog, got.backlog);
            $display("%0t:   ptotal %h/%h btotal %h/%h (expected/actual)",
                     $time, want.ptotal, got.ptotal, want.btotal, got.btotal);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/shaper_node_table_with_counters_top_test.sv
module shaper_node_table_with_counters_top_test;
  import snt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  int               errors, pending, results_seen;
  int               hold_cycles = 0;
  logic             hold_go = 0;
  logic             hold_done = 0;
  logic             calm = 0;
  int               ops_sent = 0;

  shaper_node_table_with_counters_top i_dut (.*);

  shaper_node_table_with_counters_checker i_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .errors, .pending, .results_seen
  );

  initial forever #6 clk = ~clk;

  initial begin
    #80ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cycles <= 600;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  function automatic logic [IN_W-1:0] pack_op(logic [2:0] op, int n, int hp, int p,
                                              int nw, int by, int sc);
    return {2'(sc), 16'(by), 6'(nw), 6'(p), 1'(hp), 6'(n), op};
  endfunction

  task automatic send_op(logic [IN_W-1:0] w);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent++;
  endtask

  // A random operation, some malformed, mostly on slots 0-11 so links form.
  task automatic send_random();
    int k, n, p, nw;
    logic [2:0] op;
    k = $urandom_range(99);
    n = $urandom_range(11);
    p = $urandom_range(11);
    nw = $urandom_range(11);
    if (k < 5) begin
      n = $urandom_range(63); p = $urandom_range(63); nw = $urandom_range(63);
    end
    if (k < 3) op = 3'($urandom_range(7, 6));
    else if (k < 22) op = OP_ADD;
    else if (k < 30) op = OP_DELETE;
    else if (k < 55) op = OP_ENQUEUE;
    else if (k < 68) op = OP_DEQUEUE;
    else if (k < 88) op = OP_STATS;
    else op = OP_REPLACE;
    send_op(pack_op(op, n, int'($urandom_range(1)), p, nw, int'($urandom_range(65535)),
                    ($urandom_range(9) == 0) ? 0 : int'($urandom_range(3, 1))));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    calm = 1;
    send_op(pack_op(OP_ADD, 0, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_ADD, 0, 0, 0, 0, 0, 3));
    send_op(pack_op(OP_ADD, 0, 0, 0, 0, 0, 1));
    send_op(pack_op(OP_ADD, 63, 1, 5, 0, 0, 2));
    for (int i = 1; i <= 9; i++) send_op(pack_op(OP_ADD, i, 1, 0, 0, 0, 1));
    send_op(pack_op(OP_ADD, 10, 1, 10, 0, 0, 1));
    send_op(pack_op(OP_ENQUEUE, 1, 0, 0, 0, 65535, 0));
    send_op(pack_op(OP_DEQUEUE, 2, 0, 0, 0, 65535, 0));
    send_op(pack_op(OP_DEQUEUE, 2, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_STATS, 2, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_STATS, 0, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_REPLACE, 1, 0, 0, 40, 0, 0));
    send_op(pack_op(OP_REPLACE, 1, 0, 0, 41, 0, 0));
    send_op(pack_op(OP_DELETE, 3, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_DELETE, 0, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_ENQUEUE, 4, 0, 0, 0, 32768, 0));
    send_op(pack_op(OP_DELETE, 3, 0, 0, 0, 0, 0));
    send_op(pack_op(OP_STATS, 63, 0, 0, 0, 0, 0));
    send_op(pack_op(3'd7, 0, 0, 0, 0, 0, 0));
    calm = 0;
    for (int i = 0; i < 1150; i++) begin
      if (i == 300) hold_go = 1'b1;
      if (i >= 700 && i < 820) calm = 1;
      else calm = 0;
      send_random();
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d operations and checked %0d result words, covering every opcode,",
             ops_sent, results_seen);
    $display("full child lists, replaces, stale links, counter wrap and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: shaper_node_table_with_counters_top.f
hdl/snt_pkg.sv
hdl/shaper_node_table_with_counters_top.sv
hdl/snt_checker.sv
tb/sv/shaper_node_table_with_counters_checker.sv
tb/sv/shaper_node_table_with_counters_top_test.sv
